// ===== rtl/point_to_line_distance_defines.svh =====
// Assertion macros for the point-to-line distance RTL.
// Used by files that check their own pipeline; expects aclk and aresetn in scope.
`ifndef POINT_TO_LINE_DISTANCE_DEFINES_SVH
`define POINT_TO_LINE_DISTANCE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PTLD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PTLD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptld_pkg.sv =====
// Shared constants and types for the point-to-line distance pipeline.
// No dependencies; imported by the root unit, the top level and the testbench.
package ptld_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int DIST_WIDTH       = 32;
    localparam int FRAC_BITS        = 16;
    localparam int MIN_OFFSET_WIDTH = 17;
    localparam logic [MIN_OFFSET_WIDTH-1:0] MIN_OFFSET_RESET = 17'd1;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_BEHIND   = 2'd1,
        ST_ZERO_DIR = 2'd2
    } status_t;

    // Per-stage control that travels with the data
    typedef struct packed {
        logic    vld;
        status_t st;
    } ptld_ctl_t;

endpackage

// ===== rtl/point_to_line_distance.sv =====
// Pipeline: 7 arithmetic stages, 1 divide setup, 64 quotient stages, 32 root stages,
//   1 output register.
// Throughput: one item per cycle; the whole pipeline holds while the output waits.
// Reset (aresetn low, synchronous) empties every stage and sets min_offset to 1.
// Depends on ptld_pkg, ptld_mul, ptld_root and point_to_line_distance_defines.svh.
`include "point_to_line_distance_defines.svh"
module point_to_line_distance
    import ptld_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int S_TDATA_W  = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [MIN_OFFSET_WIDTH-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // point_x, point_y, point_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [S_TDATA_W-1:0]        s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // distance
    output logic [DIST_WIDTH-1:0]       m_tdata,
    // status
    output logic [1:0]                  m_tuser
);
    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int PW   = 2 * DW;
    localparam int LW   = 2 * W;
    localparam int DTW  = PW + 2;
    localparam int CW   = PW + 1;
    localparam int NW   = 2 * CW;
    localparam int TPW  = MIN_OFFSET_WIDTH + LW + 2;
    localparam int CMPW = (TPW > DTW + FRAC_BITS) ? TPW : DTW + FRAC_BITS;

    logic adv;
    logic s_accept;

    logic [MIN_OFFSET_WIDTH-1:0] min_offset_reg;
    logic [7:1]                  vld_reg;

    logic signed [W-1:0]  pt   [3];
    logic signed [W-1:0]  org  [3];
    logic signed [W-1:0]  dirv [3];
    logic signed [DW-1:0] d_reg [3];
    logic signed [W-1:0]  v_reg [3];
    logic signed [DW-1:0] vx    [3];

    logic signed [DW-1:0] ma [12];
    logic signed [DW-1:0] mb [12];
    logic signed [PW-1:0] mp [12];

    logic [LW-1:0]         len2_next, len4_reg, len5_reg, len6_reg, len7_reg;
    logic signed [DTW-1:0] dot_next, dot4_reg, dot5_reg, dot6_reg;
    logic signed [CW-1:0]  cr_next [3];
    logic signed [CW-1:0]  cr_reg  [3];
    logic signed [2*CW-1:0] sq [3];
    logic signed [TPW-1:0] thr_p;

    logic [NW-1:0]   csq_next, csq_reg;
    logic [CMPW-1:0] lhs, rhs;
    status_t         st7_next, st7_reg;

    ptld_ctl_t             root_in_ctl, root_out_ctl;
    logic [DIST_WIDTH-1:0] root_val;

    logic                  m_tvalid_reg;
    logic [DIST_WIDTH-1:0] m_tdata_reg;
    status_t               m_tuser_reg;

    // Advance the whole pipeline unless a result is held at the output
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && adv;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_offset_reg <= MIN_OFFSET_RESET;
        end else if (cfg_we) begin
            min_offset_reg <= cfg_wdata;
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[6:1], s_accept};
        end
    end

    // Unpack the input transfer
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign pt[i]   = s_tdata[i*W +: W];
        assign org[i]  = s_tdata[(3+i)*W +: W];
        assign dirv[i] = s_tdata[(6+i)*W +: W];
        assign vx[i]   = {v_reg[i][W-1], v_reg[i]};
    end

    // Stage 1: offset from origin
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= {pt[i][W-1], pt[i]} - {org[i][W-1], org[i]};
                v_reg[i] <= dirv[i];
            end
        end
    end

    // Stages 2-3: squares, dot terms and cross terms
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ma[i]   = vx[i];
            mb[i]   = vx[i];
            ma[3+i] = d_reg[i];
            mb[3+i] = vx[i];
        end
        ma[6]  = d_reg[1]; mb[6]  = vx[2];
        ma[7]  = d_reg[2]; mb[7]  = vx[1];
        ma[8]  = d_reg[2]; mb[8]  = vx[0];
        ma[9]  = d_reg[0]; mb[9]  = vx[2];
        ma[10] = d_reg[0]; mb[10] = vx[1];
        ma[11] = d_reg[1]; mb[11] = vx[0];
    end

    for (genvar k = 0; k < 12; k++) begin : g_mul_a
        ptld_mul #(.AW(DW), .BW(DW)) u_mul (
            .aclk (aclk),
            .adv  (adv),
            .a    (ma[k]),
            .b    (mb[k]),
            .p    (mp[k])
        );
    end

    // Stage 4: length squared, dot product, cross product
    always_comb begin
        logic [PW+1:0] lsum;
        lsum      = {{2{mp[0][PW-1]}}, mp[0]} + {{2{mp[1][PW-1]}}, mp[1]}
                  + {{2{mp[2][PW-1]}}, mp[2]};
        len2_next = lsum[LW-1:0];
        dot_next  = $signed({{2{mp[3][PW-1]}}, mp[3]} + {{2{mp[4][PW-1]}}, mp[4]}
                  + {{2{mp[5][PW-1]}}, mp[5]});
        cr_next[0] = $signed({mp[6][PW-1], mp[6]} - {mp[7][PW-1], mp[7]});
        cr_next[1] = $signed({mp[8][PW-1], mp[8]} - {mp[9][PW-1], mp[9]});
        cr_next[2] = $signed({mp[10][PW-1], mp[10]} - {mp[11][PW-1], mp[11]});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            len4_reg <= len2_next;
            dot4_reg <= dot_next;
            for (int i = 0; i < 3; i++) begin
                cr_reg[i] <= cr_next[i];
            end
        end
    end

    // Stages 5-6: cross squares and threshold product
    for (genvar i = 0; i < 3; i++) begin : g_mul_sq
        ptld_mul #(.AW(CW), .BW(CW)) u_sq (
            .aclk (aclk),
            .adv  (adv),
            .a    (cr_reg[i]),
            .b    (cr_reg[i]),
            .p    (sq[i])
        );
    end

    ptld_mul #(.AW(MIN_OFFSET_WIDTH + 1), .BW(LW + 1)) u_thr (
        .aclk (aclk),
        .adv  (adv),
        .a    ($signed({1'b0, min_offset_reg})),
        .b    ($signed({1'b0, len4_reg})),
        .p    (thr_p)
    );

    // Hold length and dot alongside the multipliers
    always_ff @(posedge aclk) begin
        if (adv) begin
            len5_reg <= len4_reg;
            len6_reg <= len5_reg;
            dot5_reg <= dot4_reg;
            dot6_reg <= dot5_reg;
        end
    end

    // Stage 7: cross magnitude squared and status
    always_comb begin
        csq_next = NW'($unsigned(sq[0])) + NW'($unsigned(sq[1])) + NW'($unsigned(sq[2]));
        lhs      = CMPW'({dot6_reg, {FRAC_BITS{1'b0}}});
        rhs      = CMPW'($unsigned(thr_p));
        priority if (len6_reg == '0) begin
            st7_next = ST_ZERO_DIR;
        end else if (dot6_reg[DTW-1] || (lhs < rhs)) begin
            st7_next = ST_BEHIND;
        end else begin
            st7_next = ST_VALID;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            csq_reg  <= csq_next;
            len7_reg <= len6_reg;
            st7_reg  <= st7_next;
        end
    end

    // Divide and root
    assign root_in_ctl = '{vld: vld_reg[7], st: st7_reg};

    ptld_root #(.NW(NW), .LW(LW)) u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_ctl  (root_in_ctl),
        .csq     (csq_reg),
        .len2    (len7_reg),
        .out_ctl (root_out_ctl),
        .root    (root_val)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= root_out_ctl.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= (root_out_ctl.st == ST_VALID) ? root_val : {DIST_WIDTH{1'b1}};
            m_tuser_reg <= root_out_ctl.st;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `PTLD_ASSERT_IMP(a_flag_dist, m_tvalid && (m_tuser != ST_VALID), m_tdata == '1, "nonzero status without all-ones distance")
    `PTLD_ASSERT_NXT(a_stall_hold, !adv, $stable(vld_reg) && $stable(csq_reg), "pipeline moved during stall")
    `PTLD_ASSERT_NXT(a_accept_enter, s_tvalid && s_tready, vld_reg[1], "accepted transfer not captured")

endmodule

// ===== rtl/ptld_mul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
// Standalone; instantiated by the point-to-line distance top level.
module ptld_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                      aclk,
    input  logic                      adv,
    input  logic signed [AW-1:0]      a,
    input  logic signed [BW-1:0]      b,
    output logic signed [AW+BW-1:0]   p
);
    localparam int HA = AW / 2;
    localparam int HB = BW / 2;
    localparam int PW = AW + BW;

    logic        [HA-1:0]              al;
    logic signed [AW-HA-1:0]           ah;
    logic        [HB-1:0]              bl;
    logic signed [BW-HB-1:0]           bh;
    logic        [HA+HB-1:0]           pll_next, pll_reg;
    logic signed [HA+BW-HB:0]          plh_next, plh_reg;
    logic signed [AW-HA+HB:0]          phl_next, phl_reg;
    logic signed [AW-HA+BW-HB-1:0]     phh_next, phh_reg;
    logic signed [PW-1:0]              p_next, p_reg;

    assign al = a[HA-1:0];
    assign ah = a[AW-1:HA];
    assign bl = b[HB-1:0];
    assign bh = b[BW-1:HB];

    // Form the partial products
    assign pll_next = al * bl;
    assign plh_next = $signed({1'b0, al}) * bh;
    assign phl_next = ah * $signed({1'b0, bl});
    assign phh_next = ah * bh;

    // Align and add the partial products
    assign p_next = ($signed(PW'(phh_reg)) <<< (HA + HB))
                  + ($signed(PW'(plh_reg)) <<< HB)
                  + ($signed(PW'(phl_reg)) <<< HA)
                  + $signed(PW'(pll_reg));

    always_ff @(posedge aclk) begin
        if (adv) begin
            pll_reg <= pll_next;
            plh_reg <= plh_next;
            phl_reg <= phl_next;
            phh_reg <= phh_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/ptld_root.sv =====
// Pipelined restoring divide of |d x V|^2 by |V|^2, then bit-per-stage integer root.
// Depends on ptld_pkg for the control struct and result width.
module ptld_root
    import ptld_pkg::*;
#(
    parameter int NW = 130,
    parameter int LW = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  ptld_ctl_t             in_ctl,
    input  logic [NW-1:0]         csq,
    input  logic [LW-1:0]         len2,
    output ptld_ctl_t             out_ctl,
    output logic [DIST_WIDTH-1:0] root
);
    localparam int QW  = 2 * DIST_WIDTH;
    localparam int RW  = DIST_WIDTH;
    localparam int DVW = (NW > LW + QW) ? NW : LW + QW;

    ptld_ctl_t         dctl_reg [QW+1];
    logic [DVW-1:0]    drem_reg [QW+1];
    logic [QW-1:0]     dq_reg   [QW+1];
    logic [LW-1:0]     dlen_reg [QW+1];
    logic              dsat_reg [QW+1];

    ptld_ctl_t         sctl     [RW+1];
    logic [QW:0]       srem     [RW+1];
    logic [RW-1:0]     sroot    [RW+1];

    logic [DVW-1:0]    len_top;

    // Quotient at or above 2^QW saturates the root to all ones
    assign len_top = DVW'(len2) << QW;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dctl_reg[0] <= '0;
        end else if (adv) begin
            dctl_reg[0] <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            drem_reg[0] <= DVW'(csq);
            dq_reg[0]   <= '0;
            dlen_reg[0] <= len2;
            dsat_reg[0] <= (DVW'(csq) >= len_top);
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int B = QW - 1 - k;
        logic [DVW-1:0] sh;
        logic           ge;

        assign sh = DVW'(dlen_reg[k]) << B;
        assign ge = !dsat_reg[k] && (drem_reg[k] >= sh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dctl_reg[k+1] <= '0;
            end else if (adv) begin
                dctl_reg[k+1] <= dctl_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                drem_reg[k+1] <= ge ? drem_reg[k] - sh : drem_reg[k];
                dq_reg[k+1]   <= ge ? (dq_reg[k] | (QW'(1) << B)) : dq_reg[k];
                dlen_reg[k+1] <= dlen_reg[k];
                dsat_reg[k+1] <= dsat_reg[k];
            end
        end
    end

    // Feed the root stages with the saturated quotient
    assign sctl[0]  = dctl_reg[QW];
    assign srem[0]  = {1'b0, (dsat_reg[QW] ? {QW{1'b1}} : dq_reg[QW])};
    assign sroot[0] = '0;

    // One root bit per stage: keep remainder q - r^2
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int B = RW - 1 - k;
        logic [QW:0] t;
        logic        ge;

        assign t  = ((QW+1)'(sroot[k]) << (B + 1)) + ((QW+1)'(1) << (2 * B));
        assign ge = (srem[k] >= t);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sctl[k+1] <= '0;
            end else if (adv) begin
                sctl[k+1] <= sctl[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                srem[k+1]  <= ge ? srem[k] - t : srem[k];
                sroot[k+1] <= ge ? (sroot[k] | (RW'(1) << B)) : sroot[k];
            end
        end
    end

    assign out_ctl = sctl[RW];
    assign root    = sroot[RW];

endmodule

// ===== tb/point_to_line_distance_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the point-to-line distance block: watches both stream channels,
// computes the expected distance and status of each accepted query and compares.
// Depends on ptld_pkg.
module point_to_line_distance_checker
    import ptld_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [MIN_OFFSET_WIDTH-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [287:0]                s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [DIST_WIDTH-1:0]       m_tdata,
    input  logic [1:0]                  m_tuser,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic [31:0] distance;
        status_t     st;
    } answer_t;

    answer_t                     answers_due[$];
    logic [MIN_OFFSET_WIDTH-1:0] threshold;

    assign pending = answers_due.size();

    // Exact distance query: all products fit easily in 320-bit signed arithmetic
    function automatic answer_t query_answer(input logic [287:0] q,
                                             input logic [MIN_OFFSET_WIDTH-1:0] thr);
        logic signed [319:0] d[3];
        logic signed [319:0] v[3];
        logic signed [319:0] len2, dotp, c0, c1, c2, csq, trial;
        logic [31:0]         r, cand;
        answer_t             a;
        for (int i = 0; i < 3; i++) begin
            d[i] = $signed(q[32*i +: 32]) - $signed(q[32*(3+i) +: 32]);
            v[i] = $signed(q[32*(6+i) +: 32]);
        end
        len2 = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        if (len2 == 0) begin
            a.distance = '1;
            a.st       = ST_ZERO_DIR;
            return a;
        end
        dotp = d[0]*v[0] + d[1]*v[1] + d[2]*v[2];
        if (dotp * 65536 < $signed({303'd0, thr}) * len2) begin
            a.distance = '1;
            a.st       = ST_BEHIND;
            return a;
        end
        c0  = d[1]*v[2] - d[2]*v[1];
        c1  = d[2]*v[0] - d[0]*v[2];
        c2  = d[0]*v[1] - d[1]*v[0];
        csq = c0*c0 + c1*c1 + c2*c2;
        // bitwise root: largest r with r^2 * |V|^2 <= |d x V|^2
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            cand  = r | (32'd1 << b);
            trial = $signed({288'd0, cand}) * $signed({288'd0, cand}) * len2;
            if (trial <= csq) r = cand;
        end
        a.distance = r;
        a.st       = ST_VALID;
        return a;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            threshold  <= MIN_OFFSET_RESET;
            fail_count <= 0;
            answers_due.delete();
        end else begin
            if (cfg_we) threshold <= cfg_wdata;
            // predict on each input transfer
            if (s_tvalid && s_tready) answers_due.push_back(query_answer(s_tdata, threshold));
            // compare each output transfer
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result dist=%h status=%0d",
                             $time, m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    answer_t e;
                    e = answers_due.pop_front();
                    if (e.distance !== m_tdata || e.st !== m_tuser) begin
                        $display("%0t: expected dist=%h status=%0d, actual dist=%h status=%0d",
                                 $time, e.distance, e.st, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/point_to_line_distance_tb.sv =====
`timescale 1ns / 1ps
// Top of the point-to-line distance testbench: clock, reset, query, threshold and stall stimulus.
// Depends on ptld_pkg, the block and point_to_line_distance_checker.
module point_to_line_distance_tb;
    import ptld_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PIPE_DEPTH     = 105;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [MIN_OFFSET_WIDTH-1:0] cfg_wdata = '0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [287:0]                s_tdata = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [DIST_WIDTH-1:0]       m_tdata;
    logic [1:0]                  m_tuser;
    int                          fail_count;
    int                          pending;
    int                          idle_cycles = 0;
    logic                        gaps_on = 1'b1;

    point_to_line_distance dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    point_to_line_distance_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (!gaps_on || sel < 55) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side stalls
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            @(posedge aclk);
            n = gap_len();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_query(input logic [31:0] f[9]);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        for (int i = 0; i < 9; i++) s_tdata[32*i +: 32] <= f[i];
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 10) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [MIN_OFFSET_WIDTH-1:0] val);
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return 32'($signed($urandom_range(0, 1 << 14)) - (1 << 13));
        endcase
    endfunction

    task automatic random_queries(input int count);
        logic [31:0] f[9];
        int          mode;
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(0, 2);
            for (int i = 0; i < 9; i++) f[i] = rand_coord(mode);
            case ($urandom_range(0, 9))
                0: begin f[6] = 0; f[7] = 0; f[8] = 0; end
                // point on the line: distance zero, offset near the threshold
                1: begin
                    f[6] = rand_coord(2); f[7] = rand_coord(2); f[8] = rand_coord(2);
                    for (int i = 0; i < 3; i++) f[i] = f[3+i] + f[6+i];
                end
                2: begin
                    for (int i = 0; i < 3; i++) f[i] = f[3+i];
                end
                3: begin
                    f[6] = $urandom_range(0, 3); f[7] = 0; f[8] = 0;
                end
                default: ;
            endcase
            send_query(f);
        end
    endtask

    initial begin
        logic [31:0] f[9];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero direction, behind, on-origin, far away
        f = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        send_query(f);
        f = '{32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0};
        send_query(f);
        f = '{32'hFFFF0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0};
        send_query(f);
        f = '{32'h10000, 32'h30000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0};
        send_query(f);
        f = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        send_query(f);
        f = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000};
        send_query(f);
        f = '{32'h1, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1};
        send_query(f);
        f = '{32'h0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h80000000, 32'h0, 32'h1, 32'h0, 32'h0};
        send_query(f);
        f = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0,
              32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        send_query(f);
        f = '{32'h5, 32'h7, 32'h0, 32'h5, 32'h7, 32'h0, 32'h0, 32'h0, 32'h0};
        send_query(f);
        random_queries(150);
        drain();

        // threshold zero: a zero dot product counts as valid
        write_threshold('0);
        f = '{32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0};
        send_query(f);
        random_queries(150);
        drain();

        // one whole unit, then the largest value the register holds
        write_threshold(17'h10000);
        f = '{32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0};
        send_query(f);
        random_queries(150);
        drain();
        write_threshold(17'h1FFFF);
        random_queries(150);
        drain();
        write_threshold(17'($urandom_range(0, 65536)));
        gaps_on = 1'b0;
        random_queries(100);
        gaps_on = 1'b1;
        random_queries(100);
        drain();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ptld_pkg.sv
rtl/ptld_mul.sv
rtl/ptld_root.sv
rtl/point_to_line_distance.sv
tb/point_to_line_distance_checker.sv
tb/point_to_line_distance_tb.sv
